[sv/rrml_pkg.sv]
`timescale 1ns / 1ps

package rrml_pkg;

   localparam int LEN_WIDTH = 7;
   localparam logic [LEN_WIDTH-1:0] LEN_RESET = 7'd64;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   // control part of a word moving down the chain
   typedef struct packed {
      logic valid;
      logic kind;
      logic hit;
   } ctl_type;

endpackage

[sv/rrml_req_if.sv]
`timescale 1ns / 1ps

interface rrml_req_if #(
   parameter int CODE_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [CODE_WIDTH-1:0] code;

   modport source (output valid, output kind, output code, input ready);
   modport sink (input valid, input kind, input code, output ready);
endinterface

[sv/rrml_rsp_if.sv]
`timescale 1ns / 1ps

interface rrml_rsp_if #(
   parameter int CNT_WIDTH = 7
);
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [CNT_WIDTH-1:0] fill_count;

   modport source (output valid, output hit, output fill_count, input ready);
   modport sink (input valid, input hit, input fill_count, output ready);
endinterface

[sv/rrml_seq.sv]
`timescale 1ns / 1ps

module rrml_seq #(
   parameter int DEPTH     = 64,
   parameter int CODE_WIDTH = 32,
   parameter int IDX_WIDTH = 6,
   parameter int CNT_WIDTH = 7
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rrml_pkg::LEN_WIDTH-1:0]  csr_wdata,
   input  logic                            accept,
   input  logic                            kind,
   input  logic [CODE_WIDTH-1:0]           code,
   output rrml_pkg::ctl_type               ctl_out,
   output logic [CODE_WIDTH-1:0]           code_out,
   output logic [IDX_WIDTH-1:0]            ptr_out,
   output logic [CNT_WIDTH-1:0]            count_out
);
   import rrml_pkg::*;

   localparam int LW = (LEN_WIDTH > CNT_WIDTH) ? LEN_WIDTH : CNT_WIDTH;

   logic [LEN_WIDTH-1:0] list_length_ff;
   logic [IDX_WIDTH-1:0] wp_ff, wp_in;
   logic [CNT_WIDTH-1:0] vc_ff, vc_in;

   logic [LW-1:0]        len_raw;
   logic [LW-1:0]        depth_w;
   logic [CNT_WIDTH-1:0] len_eff;
   logic [IDX_WIDTH-1:0] p;
   logic [CNT_WIDTH-1:0] p_next;
   logic [CNT_WIDTH-1:0] vc_inc;
   logic                 is_insert;

   always_comb begin
      len_raw = LW'(list_length_ff);
      depth_w = LW'(DEPTH);
      if (len_raw == '0) begin
         len_eff = CNT_WIDTH'(1);
      end else if (len_raw > depth_w) begin
         len_eff = CNT_WIDTH'(depth_w);
      end else begin
         len_eff = CNT_WIDTH'(len_raw);
      end

      // wrap first when the length shrank below the pointer
      p = (CNT_WIDTH'(wp_ff) >= len_eff) ? '0 : wp_ff;
      p_next = CNT_WIDTH'(p) + CNT_WIDTH'(1);
      vc_inc = (vc_ff < len_eff) ? vc_ff + CNT_WIDTH'(1) : vc_ff;
      is_insert = (kind == KIND_INSERT);

      wp_in = wp_ff;
      vc_in = vc_ff;
      if (accept && is_insert) begin
         wp_in = (p_next >= len_eff) ? '0 : IDX_WIDTH'(p_next);
         vc_in = vc_inc;
      end

      ctl_out.valid = accept;
      ctl_out.kind  = kind;
      ctl_out.hit   = 1'b0;
      code_out      = code;
      ptr_out       = p;
      // lookups carry the compare bound, which is also the fill count
      if (is_insert) begin
         count_out = (vc_inc < len_eff) ? vc_inc : len_eff;
      end else begin
         count_out = (vc_ff < len_eff) ? vc_ff : len_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         list_length_ff <= LEN_RESET;
         wp_ff          <= '0;
         vc_ff          <= '0;
      end else begin
         if (csr_we) begin
            list_length_ff <= csr_wdata;
         end
         wp_ff <= wp_in;
         vc_ff <= vc_in;
      end
   end

endmodule

[sv/rrml_cell.sv]
`timescale 1ns / 1ps

module rrml_cell #(
   parameter int CODE_WIDTH = 32,
   parameter int IDX_WIDTH  = 6,
   parameter int CNT_WIDTH  = 7,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  rrml_pkg::ctl_type     ctl_in,
   input  logic [CODE_WIDTH-1:0] code_in,
   input  logic [IDX_WIDTH-1:0]  ptr_in,
   input  logic [CNT_WIDTH-1:0]  count_in,
   output rrml_pkg::ctl_type     ctl_out,
   output logic [CODE_WIDTH-1:0] code_out,
   output logic [IDX_WIDTH-1:0]  ptr_out,
   output logic [CNT_WIDTH-1:0]  count_out
);
   import rrml_pkg::*;

   logic [CODE_WIDTH-1:0] entry_ff;
   ctl_type               ctl_ff, ctl_in_next;
   logic [CODE_WIDTH-1:0] code_ff;
   logic [IDX_WIDTH-1:0]  ptr_ff;
   logic [CNT_WIDTH-1:0]  count_ff;
   logic                  write_en;
   logic                  match;

   always_comb begin
      write_en = advance && ctl_in.valid && (ctl_in.kind == KIND_INSERT)
                 && (ptr_in == IDX_WIDTH'(INDEX));
      // compare only entries below the fill count
      match = ctl_in.valid && (ctl_in.kind == KIND_LOOKUP)
              && (CNT_WIDTH'(INDEX) < count_in) && (entry_ff == code_in);
      ctl_in_next     = ctl_in;
      ctl_in_next.hit = ctl_in.hit | match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= code_in;
      end
      if (advance) begin
         code_ff  <= code_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign code_out  = code_ff;
   assign ptr_out   = ptr_ff;
   assign count_out = count_ff;

endmodule

[sv/recency_ring_membership_list.sv]
// Each accepted word passes through the DEPTH cell registers to its result, one per advance.
// Throughput: one word per cycle while the chain moves; each word walks all DEPTH cells.
// The chain stalls as a whole while the result at its end is not taken.
// Reset: synchronous; clears write pointer, fill count and chain valids, list_length to 64.
// Entries are not cleared; only entries below the fill count are compared.
`timescale 1ns / 1ps

module recency_ring_membership_list #(
   parameter int DEPTH      = 64,
   parameter int CODE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   rrml_req_if.sink                       req_ch,
   rrml_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [rrml_pkg::LEN_WIDTH-1:0] csr_wdata
);
   import rrml_pkg::*;

   localparam int IDX_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   ctl_type               ctl_w   [DEPTH+1];
   logic [CODE_WIDTH-1:0] code_w  [DEPTH+1];
   logic [IDX_WIDTH-1:0]  ptr_w   [DEPTH+1];
   logic [CNT_WIDTH-1:0]  count_w [DEPTH+1];

   logic advance;
   logic accept;

   // move the chain whenever the last word is empty or being taken
   assign advance = !ctl_w[DEPTH].valid || rsp_ch.ready;
   assign accept  = req_ch.valid && advance;
   assign req_ch.ready = advance;

   rrml_seq #(
      .DEPTH(DEPTH),
      .CODE_WIDTH(CODE_WIDTH),
      .IDX_WIDTH(IDX_WIDTH),
      .CNT_WIDTH(CNT_WIDTH)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .accept(accept),
      .kind(req_ch.kind),
      .code(req_ch.code),
      .ctl_out(ctl_w[0]),
      .code_out(code_w[0]),
      .ptr_out(ptr_w[0]),
      .count_out(count_w[0])
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rrml_cell #(
         .CODE_WIDTH(CODE_WIDTH),
         .IDX_WIDTH(IDX_WIDTH),
         .CNT_WIDTH(CNT_WIDTH),
         .INDEX(i)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .ctl_in(ctl_w[i]),
         .code_in(code_w[i]),
         .ptr_in(ptr_w[i]),
         .count_in(count_w[i]),
         .ctl_out(ctl_w[i+1]),
         .code_out(code_w[i+1]),
         .ptr_out(ptr_w[i+1]),
         .count_out(count_w[i+1])
      );
   end

   assign rsp_ch.valid      = ctl_w[DEPTH].valid;
   assign rsp_ch.hit        = ctl_w[DEPTH].hit;
   assign rsp_ch.fill_count = count_w[DEPTH];

endmodule
